/* design/ps2s2a_pkg.sv */
`timescale 1ns / 1ps

package ps2s2a_pkg;

  localparam logic [7:0] CODE_EXTENDED = 8'hE0;
  localparam logic [7:0] CODE_BREAK    = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT   = 8'h12;
  localparam logic [7:0] CODE_RSHIFT   = 8'h59;
  localparam logic [7:0] CODE_CAPS     = 8'h58;
  localparam logic [7:0] CMD_LEDS      = 8'hED;
  localparam logic [7:0] LED_CAPS      = 8'h04;
  localparam logic [7:0] LED_NONE      = 8'h00;
  localparam logic [7:0] CHAR_NONE     = 8'h00;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = $clog2(QDEPTH);
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  // one queued action: a character, or a caps press carrying its LED byte
  typedef struct packed {
    logic       caps;
    logic [7:0] value;
  } act_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] plain_char(input logic [7:0] code);
    logic [7:0] c;
    unique case (code)
      8'h1C: c = "a";  8'h32: c = "b";  8'h21: c = "c";  8'h23: c = "d";
      8'h24: c = "e";  8'h2B: c = "f";  8'h34: c = "g";  8'h33: c = "h";
      8'h43: c = "i";  8'h3B: c = "j";  8'h42: c = "k";  8'h4B: c = "l";
      8'h3A: c = "m";  8'h31: c = "n";  8'h44: c = "o";  8'h4D: c = "p";
      8'h15: c = "q";  8'h2D: c = "r";  8'h1B: c = "s";  8'h2C: c = "t";
      8'h3C: c = "u";  8'h2A: c = "v";  8'h1D: c = "w";  8'h22: c = "x";
      8'h35: c = "y";  8'h1A: c = "z";  8'h45: c = "0";  8'h16: c = "1";
      8'h1E: c = "2";  8'h26: c = "3";  8'h25: c = "4";  8'h2E: c = "5";
      8'h36: c = "6";  8'h3D: c = "7";  8'h3E: c = "8";  8'h46: c = "9";
      8'h5A: c = 8'h0A; 8'h29: c = " "; 8'h66: c = 8'h08; 8'h0D: c = 8'h09;
      8'h41: c = ",";  8'h49: c = ".";  8'h4A: c = ";";  8'h4E: c = "-";
      8'h55: c = "=";  8'h0E: c = 8'h27;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upper_char(input logic [7:0] code);
    logic [7:0] c;
    unique case (code)
      8'h1C: c = "A";  8'h32: c = "B";  8'h21: c = "C";  8'h23: c = "D";
      8'h24: c = "E";  8'h2B: c = "F";  8'h34: c = "G";  8'h33: c = "H";
      8'h43: c = "I";  8'h3B: c = "J";  8'h42: c = "K";  8'h4B: c = "L";
      8'h3A: c = "M";  8'h31: c = "N";  8'h44: c = "O";  8'h4D: c = "P";
      8'h15: c = "Q";  8'h2D: c = "R";  8'h1B: c = "S";  8'h2C: c = "T";
      8'h3C: c = "U";  8'h2A: c = "V";  8'h1D: c = "W";  8'h22: c = "X";
      8'h35: c = "Y";  8'h1A: c = "Z";  8'h45: c = ")";  8'h16: c = "!";
      8'h1E: c = "@";  8'h26: c = "#";  8'h25: c = "$";  8'h2E: c = "%";
      8'h36: c = "^";  8'h3D: c = "&";  8'h3E: c = "*";  8'h46: c = "(";
      8'h41: c = "<";  8'h49: c = ">";  8'h4A: c = ":";  8'h4E: c = "_";
      8'h55: c = "+";  8'h0E: c = 8'h22;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

/* design/ps2s2a_front.sv */
`timescale 1ns / 1ps

module ps2s2a_front import ps2s2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_scan_byte,
  output logic       in_full,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output act_t       q_data
);

  logic shift_r, shift_nxt;
  logic caps_r, caps_nxt;
  logic brk_r, brk_nxt;
  logic accept;
  logic is_caps_make;
  logic upper;
  logic [7:0] up_c, pl_c, ch;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;

  assign is_caps_make = (in_scan_byte == CODE_CAPS) && !brk_r;

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    brk_nxt   = 1'b0;
    priority if (in_scan_byte == CODE_EXTENDED) begin
      brk_nxt = brk_r;
    end else if (in_scan_byte == CODE_BREAK) begin
      brk_nxt = 1'b1;
    end else if (in_scan_byte == CODE_LSHIFT || in_scan_byte == CODE_RSHIFT) begin
      shift_nxt = !brk_r;
    end else if (is_caps_make) begin
      caps_nxt = !caps_r;
    end else begin
      brk_nxt = 1'b0;
    end
  end

  assign upper = shift_nxt != caps_nxt;
  assign up_c  = upper_char(in_scan_byte);
  assign pl_c  = plain_char(in_scan_byte);
  assign ch    = (upper && up_c != CHAR_NONE) ? up_c : pl_c;

  always_comb begin
    q_push = 1'b0;
    q_data = '{caps: 1'b0, value: ch};
    if (accept && in_scan_byte != CODE_EXTENDED && in_scan_byte != CODE_BREAK
        && !brk_r) begin
      if (is_caps_make) begin
        q_push = 1'b1;
        q_data = '{caps: 1'b1, value: caps_nxt ? LED_CAPS : LED_NONE};
      end else if (ch != CHAR_NONE) begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
      brk_r   <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
      brk_r   <= brk_nxt;
    end
  end

endmodule

/* design/ps2s2a_fifo.sv */
`timescale 1ns / 1ps

module ps2s2a_fifo import ps2s2a_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  act_t    wdata,
  input  logic    pop,
  output act_t    rdata,
  output q_stat_t stat
);

  act_t             mem_r [QDEPTH];
  logic [QPTRW-1:0] wr_r, rd_r;
  logic [QCNTW-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.empty = cnt_r == '0;
  assign stat.full  = cnt_r == QCNTW'(QDEPTH);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == QPTRW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == QPTRW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNTW'(do_push) - QCNTW'(do_pop);
    end
  end

endmodule

/* design/ps2s2a_back.sv */
`timescale 1ns / 1ps

module ps2s2a_back import ps2s2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  act_t       q_head,
  input  q_stat_t    q_stat,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic       out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  logic       vld_r, vld_nxt;
  logic       phase_r, phase_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] value_r, value_nxt;
  logic       last_r, last_nxt;
  logic       load;

  assign load = !vld_r || out_pop;

  always_comb begin
    vld_nxt   = vld_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    if (load) begin
      priority if (phase_r) begin
        // second beat of a caps press: the LED byte
        vld_nxt   = 1'b1;
        kind_nxt  = KIND_CMD;
        value_nxt = q_head.value;
        last_nxt  = 1'b1;
        phase_nxt = 1'b0;
        q_pop     = 1'b1;
      end else if (!q_stat.empty) begin
        vld_nxt = 1'b1;
        if (q_head.caps) begin
          kind_nxt  = KIND_CMD;
          value_nxt = CMD_LEDS;
          last_nxt  = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          kind_nxt  = KIND_CHAR;
          value_nxt = q_head.value;
          last_nxt  = 1'b1;
          q_pop     = 1'b1;
        end
      end else begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
    end
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty = !vld_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

/* design/ps2_set2_scancode_to_ascii.sv */
// A result passes through the action queue, then the result register, to the out_ ports.
// Throughput: one byte per cycle while in_full is low; a caps lock press gives two
// result beats, with a two-entry action queue between decode and result stage.
// Bytes giving no result only update the shift, caps and break flags.
// Reset (rst_n low, synchronous): flags cleared, queue and result register empty.
`timescale 1ns / 1ps

module ps2_set2_scancode_to_ascii import ps2s2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_scan_byte,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic       out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  act_t    q_wdata, q_head;

  ps2s2a_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_scan_byte (in_scan_byte),
    .in_full      (in_full),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  ps2s2a_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  ps2s2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // the LED command beat is always followed at once by its LED byte
  a_caps_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last && out_pop) |=> (!out_empty && out_last && out_kind == KIND_CMD))
    else $error("caps LED byte did not follow LED command");

  a_first_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last) |-> (out_kind == KIND_CMD && out_value == CMD_LEDS))
    else $error("non-last beat is not the LED command");

  a_char_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_CHAR) |-> (out_last && out_value != CHAR_NONE))
    else $error("character beat malformed");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule
